[hdl/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and symbol mapping functions for the Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'd61;
   localparam int         QUEUE_DEPTH = 2;
   localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;
   localparam logic ALPHA_STD  = 1'b0;
   localparam logic ALPHA_URL  = 1'b1;

   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_ALPHABET  = 1'b1;

   // One unit of work for the back end: up to four result bytes.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      num;     // index of the final result byte
      logic            last;
      logic            no_data;
   } job_type;

   function automatic logic [7:0] sym_of(input logic [5:0] v, input logic alpha);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
         c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
         c = (alpha == ALPHA_URL) ? 8'd45 : 8'd43;
      end else begin
         c = (alpha == ALPHA_URL) ? 8'd95 : 8'd47;
      end
      return c;
   endfunction

   function automatic logic [5:0] val_of(input logic [7:0] ch, input logic alpha);
      logic [7:0] v;
      v = 8'd0;
      if (ch >= 8'd65 && ch <= 8'd90) begin
         v = ch - 8'd65;
      end else if (ch >= 8'd97 && ch <= 8'd122) begin
         v = ch - 8'd71;
      end else if (ch >= 8'd48 && ch <= 8'd57) begin
         v = ch + 8'd4;
      end else if (alpha == ALPHA_URL) begin
         if (ch == 8'd45) v = 8'd62;
         else if (ch == 8'd95) v = 8'd63;
      end else begin
         if (ch == 8'd43) v = 8'd62;
         else if (ch == 8'd47) v = 8'd63;
      end
      return v[5:0];
   endfunction

endpackage

[hdl/b64c_front.sv]
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input items, tracks the group state and builds result jobs.
// ----------------------------------------------------------------------------
module b64c_front
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       direction,
   input  logic       alphabet,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_in,
   input  logic       q_ready,
   output logic       q_push,
   output job_type    q_job
);

   logic [23:0] gb_ff, gb_in;
   logic [1:0]  gc_ff, gc_in;
   logic        ps_ff, ps_in;
   logic        accept;
   logic        emit;
   job_type     job;

   logic [1:0]  cnt;
   logic [23:0] sh;
   logic [23:0] bits;
   logic [23:0] gb_t;
   logic [2:0]  gc3;
   logic [1:0]  gc_t;
   logic        ps_t;
   logic        full;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && emit;
   assign q_job     = job;

   always_comb begin
      gb_in       = gb_ff;
      gc_in       = gc_ff;
      ps_in       = ps_ff;
      emit        = 1'b0;
      job         = '0;
      cnt         = 2'd0;
      sh          = 24'd0;
      bits        = 24'd0;
      gb_t        = gb_ff;
      gc3         = 3'd0;
      gc_t        = gc_ff;
      ps_t        = ps_ff;
      full        = 1'b0;
      if (direction == DIR_ENCODE) begin
         sh    = {gb_ff[15:0], req_in_byte};
         cnt   = gc_ff + 2'd1;
         gb_in = sh;
         gc_in = cnt;
         if (cnt == 2'd3 || req_last_in) begin
            case (cnt)
               2'd1:    bits = {sh[7:0], 16'd0};
               2'd2:    bits = {sh[15:0], 8'd0};
               2'd3:    bits = sh;
               default: bits = 24'd0;
            endcase
            for (int i = 0; i < 4; i++) begin
               job.data[i] = (i <= int'(cnt)) ? sym_of(bits[23-6*i -: 6], alphabet)
                                              : PAD_CHAR;
            end
            job.num  = 2'd3;
            job.last = req_last_in;
            emit     = 1'b1;
            gb_in    = 24'd0;
            gc_in    = 2'd0;
         end
         if (req_last_in) begin
            gb_in = 24'd0;
            gc_in = 2'd0;
            ps_in = 1'b0;
         end
      end else begin
         if (!ps_ff) begin
            if (req_in_byte == PAD_CHAR) begin
               ps_t = 1'b1;
            end else begin
               gb_t = {gb_ff[17:0], val_of(req_in_byte, alphabet)};
               gc3  = {1'b0, gc_ff} + 3'd1;
               gc_t = gc3[1:0];
               if (gc3 == 3'd4) begin
                  job.data[0] = gb_t[23:16];
                  job.data[1] = gb_t[15:8];
                  job.data[2] = gb_t[7:0];
                  job.num     = 2'd2;
                  job.last    = req_last_in;
                  full        = 1'b1;
                  emit        = 1'b1;
                  gb_t        = 24'd0;
               end
            end
         end
         gb_in = gb_t;
         gc_in = gc_t;
         ps_in = ps_t;
         if (req_last_in) begin
            if (!full) begin
               if (ps_t && gc_t >= 2'd2) begin
                  // padded tail: n data characters give n-1 bytes
                  bits        = (gc_t == 2'd2) ? {gb_t[11:0], 12'd0} : {gb_t[17:0], 6'd0};
                  job.data[0] = bits[23:16];
                  job.data[1] = bits[15:8];
                  job.num     = gc_t - 2'd2;
                  job.last    = 1'b1;
               end else begin
                  job.num     = 2'd0;
                  job.last    = 1'b1;
                  job.no_data = 1'b1;
               end
               emit = 1'b1;
            end
            gb_in = 24'd0;
            gc_in = 2'd0;
            ps_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gb_ff <= '0;
         gc_ff <= '0;
         ps_ff <= 1'b0;
      end else if (accept) begin
         gb_ff <= gb_in;
         gc_ff <= gc_in;
         ps_ff <= ps_in;
      end
   end

endmodule

[hdl/b64c_queue.sv]
// ----------------------------------------------------------------------------
// b64c_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module b64c_queue
   import b64c_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_job
);

   job_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ff, wr_in;
   logic [QUEUE_AW-1:0]       rd_ff, rd_in;
   logic [QUEUE_AW:0]         cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

[hdl/b64c_back.sv]
// ----------------------------------------------------------------------------
// b64c_back
// Takes queued jobs; sends their bytes one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module b64c_back
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out,
   output logic       rsp_no_data
);

   job_type    job_ff, job_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       at_end;
   logic       take;

   assign at_end       = (idx_ff == job_ff.num);
   assign rsp_valid    = busy_ff;
   assign rsp_out_byte = job_ff.data[idx_ff];
   assign rsp_last_out = job_ff.last && at_end;
   assign rsp_no_data  = job_ff.no_data;

   assign take  = rsp_valid && rsp_ready;
   assign q_pop = q_valid && (!busy_ff || (take && at_end));

   always_comb begin
      job_in  = job_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (q_pop) begin
         job_in  = q_job;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (take) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      job_ff <= job_in;
   end

endmodule

[hdl/base64_stream_codec.sv]
// A result is registered in the job queue, then in the back-end job register.
// The result port sends one byte per cycle while rsp_ready is high, which
// holds back encode (4 results per 3 items); decode takes one item per cycle
// (3 results per 4 items). Input accepts one item per cycle while the 2-entry
// job queue has room. Reset (synchronous): group state, queue and output
// clear; direction=encode, alphabet=standard. No clearing pass.
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard or URL-safe alphabet.
// ----------------------------------------------------------------------------
module base64_stream_codec
   import b64c_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_out,
   output logic       rsp_no_data
);

   logic    direction_ff;
   logic    alphabet_ff;
   logic    q_ready;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         alphabet_ff  <= ALPHA_STD;
      end else if (csr_we) begin
         case (csr_index)
            REG_DIRECTION: direction_ff <= csr_wdata;
            REG_ALPHABET:  alphabet_ff  <= csr_wdata;
            default:       ;
         endcase
      end
   end

   b64c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .direction   (direction_ff),
      .alphabet    (alphabet_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_last_in (req_last_in),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_job       (q_push_job)
   );

   b64c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_job    (q_pop_job)
   );

   b64c_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_job        (q_pop_job),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last_out (rsp_last_out),
      .rsp_no_data  (rsp_no_data)
   );

endmodule
